@@ hw/rtl/radconv_pkg.sv @@
package radconv_pkg;

    localparam int VALUE_BITS  = 16;
    localparam int MAX_DIGITS  = 16;
    localparam int DIGIT_W     = 4;
    localparam int RADIX_W     = 4;
    localparam int PLAIN_W     = 16;
    localparam int CODED_IN_W  = 54;
    localparam int CODED_OUT_W = 50;

    // bits of the coded input consumed per cycle by the decimal chain
    localparam int DEC_BITS   = 3;
    localparam int DEC_CYCLES = CODED_IN_W / DEC_BITS;

    localparam int CNT_LIMIT = (DEC_CYCLES > VALUE_BITS)
                             ? ((DEC_CYCLES > MAX_DIGITS) ? DEC_CYCLES : MAX_DIGITS)
                             : ((VALUE_BITS > MAX_DIGITS) ? VALUE_BITS : MAX_DIGITS);
    localparam int CNT_W = $clog2(CNT_LIMIT);

    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(10);

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic [APB_ADDR_W-3:0] REG_RADIX = '0;

    typedef enum logic {
        CMD_ENCODE = 1'b0,
        CMD_DECODE = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_FOLD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic clear;
        logic enc_step;
        logic dec_step;
        logic shift;
    } ctl_t;

    typedef struct packed {
        logic                  command;
        logic [PLAIN_W-1:0]    plain_value;
        logic [CODED_IN_W-1:0] coded_value;
    } in_t;

    typedef struct packed {
        logic [PLAIN_W-1:0]     plain_result;
        logic [CODED_OUT_W-1:0] coded_result;
        logic                   overflow;
    } out_t;

endpackage

@@ hw/rtl/radconv_regs.sv @@
module radconv_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [radconv_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [radconv_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [radconv_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                pready,
    output logic [radconv_pkg::RADIX_W-1:0]     base
);
    import radconv_pkg::*;

    logic [RADIX_W-1:0]      radix_reg;
    logic [RADIX_W-1:0]      radix_next;
    logic [APB_ADDR_W-3:0]   reg_index;
    logic                    wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[APB_ADDR_W-1:2];
    assign wr_en     = psel && penable && pwrite && pready;

    always_comb begin
        radix_next = radix_reg;
        if (wr_en && reg_index == REG_RADIX) begin
            radix_next = pwdata[RADIX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RADIX_RESET;
        end else begin
            radix_reg <= radix_next;
        end
    end

    always_comb begin
        unique case (reg_index)
            REG_RADIX: prdata = APB_DATA_W'(radix_reg);
            default:   prdata = '0;
        endcase
    end

    // out-of-range bases are clamped
    always_comb begin
        if (radix_reg < RADIX_MIN) begin
            base = RADIX_MIN;
        end else if (radix_reg > RADIX_MAX) begin
            base = RADIX_MAX;
        end else begin
            base = radix_reg;
        end
    end

endmodule

@@ hw/rtl/radconv_cell.sv @@
module radconv_cell (
    input  logic                              aclk,
    input  radconv_pkg::ctl_t                 ctl,
    input  logic [radconv_pkg::RADIX_W-1:0]   base,
    input  logic                              enc_cin,
    input  logic [radconv_pkg::DEC_BITS-1:0]  dec_cin,
    input  logic [radconv_pkg::DIGIT_W-1:0]   dig_in,
    output logic                              enc_cout,
    output logic [radconv_pkg::DEC_BITS-1:0]  dec_cout,
    output logic [radconv_pkg::DIGIT_W-1:0]   digit
);
    import radconv_pkg::*;

    localparam logic [DIGIT_W-1:0] DEC_LIMIT = DIGIT_W'(5);
    localparam logic [DIGIT_W-1:0] DEC_ADJ   = DIGIT_W'(3);

    logic [DIGIT_W-1:0] digit_reg;
    logic [DIGIT_W-1:0] digit_next;
    logic [DIGIT_W:0]   enc_dbl;
    logic [DIGIT_W-1:0] enc_val;
    logic [DIGIT_W-1:0] dec_val [DEC_BITS+1];
    logic [DIGIT_W-1:0] dec_adj [DEC_BITS];

    // base-n doubling step: digit*2 + carry-in, reduced modulo base
    always_comb begin
        enc_dbl  = {digit_reg, enc_cin};
        enc_cout = enc_dbl >= {1'b0, base};
        enc_val  = enc_cout ? DIGIT_W'(enc_dbl - {1'b0, base}) : enc_dbl[DIGIT_W-1:0];
    end

    // decimal shift-add-3 steps, first step on dec_cin[0]
    always_comb begin
        dec_val[0] = digit_reg;
        for (int j = 0; j < DEC_BITS; j++) begin
            dec_adj[j]   = (dec_val[j] >= DEC_LIMIT) ? dec_val[j] + DEC_ADJ : dec_val[j];
            dec_cout[j]  = dec_adj[j][DIGIT_W-1];
            dec_val[j+1] = {dec_adj[j][DIGIT_W-2:0], dec_cin[j]};
        end
    end

    always_comb begin
        digit_next = digit_reg;
        if (ctl.clear) begin
            digit_next = '0;
        end else if (ctl.enc_step) begin
            digit_next = enc_val;
        end else if (ctl.dec_step) begin
            digit_next = dec_val[DEC_BITS];
        end else if (ctl.shift) begin
            digit_next = dig_in;
        end
    end

    always_ff @(posedge aclk) begin
        digit_reg <= digit_next;
    end

    assign digit = digit_reg;

endmodule

@@ hw/rtl/radconv_fold.sv @@
module radconv_fold (
    input  logic                                aclk,
    input  radconv_pkg::ctl_t                   ctl,
    input  logic [radconv_pkg::RADIX_W-1:0]     base,
    input  logic [radconv_pkg::DIGIT_W-1:0]     digit,
    output logic [radconv_pkg::PLAIN_W-1:0]     plain_result,
    output logic [radconv_pkg::CODED_OUT_W-1:0] coded_result,
    output logic                                overflow
);
    import radconv_pkg::*;

    localparam int PROD_W = VALUE_BITS + RADIX_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam logic [SUM_W-1:0] VALUE_MAX = SUM_W'({VALUE_BITS{1'b1}});

    logic [VALUE_BITS-1:0]  dec_acc_reg;
    logic [VALUE_BITS-1:0]  dec_acc_next;
    logic                   sat_reg;
    logic                   sat_next;
    logic [CODED_OUT_W-1:0] enc_acc_reg;
    logic [CODED_OUT_W-1:0] enc_acc_next;
    logic [PROD_W-1:0]      prod;
    logic [SUM_W-1:0]       sum;
    logic                   over;

    // Horner, most significant digit first
    always_comb begin
        prod = PROD_W'(dec_acc_reg) * PROD_W'(base);
        sum  = SUM_W'(prod) + SUM_W'(digit);
        over = sat_reg || (sum > VALUE_MAX);
    end

    always_comb begin
        dec_acc_next = dec_acc_reg;
        sat_next     = sat_reg;
        enc_acc_next = enc_acc_reg;
        if (ctl.clear) begin
            dec_acc_next = '0;
            sat_next     = 1'b0;
            enc_acc_next = '0;
        end else if (ctl.shift) begin
            dec_acc_next = over ? {VALUE_BITS{1'b1}} : sum[VALUE_BITS-1:0];
            sat_next     = over;
            enc_acc_next = (enc_acc_reg << 3) + (enc_acc_reg << 1)
                         + CODED_OUT_W'(digit);
        end
    end

    always_ff @(posedge aclk) begin
        dec_acc_reg <= dec_acc_next;
        sat_reg     <= sat_next;
        enc_acc_reg <= enc_acc_next;
    end

    assign plain_result = PLAIN_W'(dec_acc_reg);
    assign coded_result = enc_acc_reg;
    assign overflow     = sat_reg;

endmodule

@@ hw/rtl/radix_converter.sv @@
// Radix converter. Command 0 spells a 16-bit value in the configured base (2 to 10, clamped)
// as decimal digits; command 1 reads a decimal-coded number as base-n digits and returns its
// binary value, saturated with an overflow flag. One transaction is worked at a time: a row
// of 16 digit cells first takes the source in (for encode one bit per cycle through a base-n
// carry chain, for decode three bits per cycle through shift-add-3 cells), then shifts its
// digits out most significant first into a multiply-accumulate. The result is loaded into
// the output register in the DONE state once any earlier result has been taken; the next
// transaction is accepted the cycle after that, even while the result still waits.
module radix_converter (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  radconv_pkg::in_t                    s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output radconv_pkg::out_t                   m_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [radconv_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [radconv_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [radconv_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                pready
);
    import radconv_pkg::*;

    state_t                 state_reg;
    state_t                 state_next;
    logic [CNT_W-1:0]       cnt_reg;
    logic [CNT_W-1:0]       cnt_next;
    logic [CNT_W-1:0]       cnt_last;
    logic                   cnt_done;
    logic                   cmd_reg;
    logic [CODED_IN_W-1:0]  src_reg;
    logic [CODED_IN_W-1:0]  src_next;
    logic                   m_valid_reg;
    logic                   m_valid_next;
    out_t                   m_data_reg;
    logic                   accept;
    logic                   load_out;
    ctl_t                   ctl;
    logic [RADIX_W-1:0]     base;

    logic [DIGIT_W-1:0]     digit   [MAX_DIGITS];
    logic                   enc_c   [MAX_DIGITS];
    logic [DEC_BITS-1:0]    dec_c   [MAX_DIGITS];

    logic [PLAIN_W-1:0]     fold_plain;
    logic [CODED_OUT_W-1:0] fold_coded;
    logic                   fold_ovf;

    radconv_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .base    (base)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    assign cnt_last = (cmd_reg == CMD_DECODE) ? CNT_W'(DEC_CYCLES - 1) : CNT_W'(VALUE_BITS - 1);
    assign cnt_done = (state_reg == ST_CONV) ? (cnt_reg == cnt_last)
                                             : (cnt_reg == CNT_W'(MAX_DIGITS - 1));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                if (cnt_done) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                if (cnt_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctl.clear    = accept;
        ctl.enc_step = (state_reg == ST_CONV) && (cmd_reg == CMD_ENCODE);
        ctl.dec_step = (state_reg == ST_CONV) && (cmd_reg == CMD_DECODE);
        ctl.shift    = (state_reg == ST_FOLD);
        load_out     = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
    end

    always_comb begin
        cnt_next = '0;
        if (state_reg == ST_CONV || state_reg == ST_FOLD) begin
            cnt_next = cnt_done ? '0 : cnt_reg + CNT_W'(1);
        end
    end

    always_comb begin
        src_next = src_reg;
        if (accept) begin
            if (s_data.command == CMD_DECODE) begin
                src_next = s_data.coded_value;
            end else begin
                src_next = {s_data.plain_value[VALUE_BITS-1:0],
                            {(CODED_IN_W - VALUE_BITS){1'b0}}};
            end
        end else if (ctl.enc_step) begin
            src_next = src_reg << 1;
        end else if (ctl.dec_step) begin
            src_next = src_reg << DEC_BITS;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        src_reg <= src_next;
        if (accept) begin
            cmd_reg <= s_data.command;
        end
        if (load_out) begin
            m_data_reg.plain_result <= (cmd_reg == CMD_DECODE) ? fold_plain : '0;
            m_data_reg.coded_result <= (cmd_reg == CMD_DECODE) ? '0 : fold_coded;
            m_data_reg.overflow     <= (cmd_reg == CMD_DECODE) ? fold_ovf : 1'b0;
        end
    end

    assign enc_c[0] = src_reg[CODED_IN_W-1];
    always_comb begin
        for (int j = 0; j < DEC_BITS; j++) begin
            dec_c[0][j] = src_reg[CODED_IN_W-1-j];
        end
    end

    for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
        if (i == 0) begin : g_first
            radconv_cell u_cell (
                .aclk     (aclk),
                .ctl      (ctl),
                .base     (base),
                .enc_cin  (enc_c[i]),
                .dec_cin  (dec_c[i]),
                .dig_in   ({DIGIT_W{1'b0}}),
                .enc_cout (enc_c[i+1]),
                .dec_cout (dec_c[i+1]),
                .digit    (digit[i])
            );
        end else if (i == MAX_DIGITS - 1) begin : g_last
            radconv_cell u_cell (
                .aclk     (aclk),
                .ctl      (ctl),
                .base     (base),
                .enc_cin  (enc_c[i]),
                .dec_cin  (dec_c[i]),
                .dig_in   (digit[i-1]),
                .enc_cout (),
                .dec_cout (),
                .digit    (digit[i])
            );
        end else begin : g_mid
            radconv_cell u_cell (
                .aclk     (aclk),
                .ctl      (ctl),
                .base     (base),
                .enc_cin  (enc_c[i]),
                .dec_cin  (dec_c[i]),
                .dig_in   (digit[i-1]),
                .enc_cout (enc_c[i+1]),
                .dec_cout (dec_c[i+1]),
                .digit    (digit[i])
            );
        end
    end

    radconv_fold u_fold (
        .aclk         (aclk),
        .ctl          (ctl),
        .base         (base),
        .digit        (digit[MAX_DIGITS-1]),
        .plain_result (fold_plain),
        .coded_result (fold_coded),
        .overflow     (fold_ovf)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_CONV) && (cnt_reg == '0))
        else $error("accepted transaction did not start conversion");

    a_fold_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FOLD) |-> (cnt_reg < CNT_W'(MAX_DIGITS)))
        else $error("fold counter past last digit");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> m_valid_reg)
        else $error("loaded result not presented");

    a_sat_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.overflow) |-> (m_data_reg.plain_result == '1))
        else $error("overflow without saturated value");

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((m_data_reg.coded_result == '0)
                     || ((m_data_reg.plain_result == '0) && !m_data_reg.overflow)))
        else $error("result carries both encode and decode fields");

endmodule
